>>> hw/rtl/ptrb_pkg.sv
package ptrb_pkg;

  localparam int BUF_DEPTH_DEF = 128;
  localparam int MAX_PKT_DEF   = 61;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int QDEPTH  = 2;

  localparam logic [BYTE_W-1:0]  SYNC_CODE  = 8'hfc;
  localparam logic [BYTE_W-1:0]  IDLE_CODE  = 8'hff;
  localparam logic [BYTE_W-1:0]  CLEAR_CODE = 8'h00;
  localparam logic [BYTE_W-1:0]  MIN_LEN    = 8'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'd127;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_LINE   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MAL   = 2'd3
  } status_t;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_DRAIN  = 1'b1
  } op_code_t;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] line_byte;
    status_t           status;
    logic              last;
  } out_item_t;

  typedef struct packed {
    op_code_t          code;
    logic [BYTE_W-1:0] data_byte;
    logic              eop;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_req_t;

endpackage

>>> hw/rtl/ptrb_chan_if.sv
interface ptrb_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/ptrb_ram.sv
module ptrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/ptrb_front.sv
module ptrb_front (
  input  logic              clk,
  input  logic              rst_n,
  ptrb_chan_if.sink         in_chan,
  input  logic              pop,
  output ptrb_pkg::op_req_t req
);
  import ptrb_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  op_t            q_r [QDEPTH];
  logic [QAW-1:0] wr_r, wr_nxt;
  logic [QAW-1:0] rd_r, rd_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           push;
  op_t            op_in;

  // classify the incoming request
  always_comb begin
    op_in.code      = in_chan.data.mode ? OP_DRAIN : OP_APPEND;
    op_in.data_byte = in_chan.data.data_byte;
    op_in.eop       = in_chan.data.end_of_packet;
  end

  assign in_chan.ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign push          = in_chan.valid && in_chan.ready;

  always_comb begin
    wr_nxt  = push ? wr_r + QAW'(1) : wr_r;
    rd_nxt  = pop ? rd_r + QAW'(1) : rd_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  assign req.valid = (cnt_r != '0);
  assign req.op    = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= op_in;
    end
  end
endmodule

>>> hw/rtl/ptrb_back.sv
module ptrb_back #(
  parameter int BUF_DEPTH = ptrb_pkg::BUF_DEPTH_DEF,
  parameter int MAX_PKT   = ptrb_pkg::MAX_PKT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ptrb_pkg::op_req_t req,
  output logic              pop,
  ptrb_chan_if.source       out_chan
);
  import ptrb_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(MAX_PKT + 1);
  localparam logic [AW-1:0]     LAST_POS = AW'(BUF_DEPTH - 1);
  localparam logic [BYTE_W-1:0] MAX_LEN  = BYTE_W'(MAX_PKT);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SYNC = 5'b00010,
    S_LENB = 5'b00100,
    S_BYTE = 5'b01000,
    S_TAIL = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       rp_r, rp_nxt;
  logic [AW-1:0]       cwp_r, cwp_nxt;
  logic [AW-1:0]       wwp_r, wwp_nxt;
  logic [COUNT_W-1:0]  bcnt_r, bcnt_nxt;
  logic [BYTE_W-1:0]   flen_r, flen_nxt;
  logic                drop_r, drop_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                ovld_r, ovld_nxt;
  out_item_t           odata_r, odata_nxt;

  logic                out_free;
  logic                we;
  logic [BYTE_W-1:0]   rd_data;
  logic [AW-1:0]       wp_next;
  logic [COUNT_W-1:0]  bcnt_inc;
  logic [BYTE_W-1:0]   flen_c;
  logic [CW-1:0]       len_c;
  logic                malformed;

  function automatic logic [AW-1:0] pos_inc(input logic [AW-1:0] p);
    pos_inc = (p == LAST_POS) ? '0 : p + AW'(1);
  endfunction

  ptrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (wwp_r),
    .wdata (req.op.data_byte),
    .raddr (rp_nxt),
    .rdata (rd_data)
  );

  assign out_free = !ovld_r || out_chan.ready;
  assign wp_next  = pos_inc(wwp_r);
  assign bcnt_inc = (bcnt_r < COUNT_MAX) ? bcnt_r + COUNT_W'(1) : bcnt_r;
  assign flen_c   = (bcnt_r == '0) ? req.op.data_byte : flen_r;
  assign len_c    = (rd_data > MAX_LEN) ? CW'(MAX_PKT) : rd_data[CW-1:0];
  assign malformed = (flen_c < MIN_LEN) || (flen_c > MAX_LEN) ||
                     (flen_c != BYTE_W'(bcnt_inc));

  always_comb begin
    state_nxt = state_r;
    rp_nxt    = rp_r;
    cwp_nxt   = cwp_r;
    wwp_nxt   = wwp_r;
    bcnt_nxt  = bcnt_r;
    flen_nxt  = flen_r;
    drop_nxt  = drop_r;
    cnt_nxt   = cnt_r;
    ovld_nxt  = ovld_r && !out_chan.ready;
    odata_nxt = odata_r;
    pop       = 1'b0;
    we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (req.valid && out_free) begin
          if (req.op.code == OP_DRAIN) begin
            if (cwp_r == rp_r) begin
              pop       = 1'b1;
              ovld_nxt  = 1'b1;
              odata_nxt = '{kind: KIND_LINE, line_byte: CLEAR_CODE,
                            status: ST_EMPTY, last: 1'b1};
            end else begin
              state_nxt = S_SYNC;
            end
          end else begin
            pop       = 1'b1;
            ovld_nxt  = 1'b1;
            odata_nxt = '{kind: KIND_STATUS, line_byte: CLEAR_CODE,
                          status: ST_OK, last: 1'b1};
            if (drop_r) begin
              // discard until end of packet
              if (req.op.eop) begin
                drop_nxt = 1'b0;
              end
              odata_nxt.status = ST_OVF;
            end else if (wp_next == rp_r) begin
              wwp_nxt          = cwp_r;
              bcnt_nxt         = '0;
              drop_nxt         = !req.op.eop;
              odata_nxt.status = ST_OVF;
            end else begin
              we       = 1'b1;
              flen_nxt = flen_c;
              wwp_nxt  = wp_next;
              bcnt_nxt = bcnt_inc;
              if (req.op.eop) begin
                bcnt_nxt = '0;
                if (malformed) begin
                  wwp_nxt          = cwp_r;
                  odata_nxt.status = ST_MAL;
                end else begin
                  cwp_nxt = wp_next;
                end
              end
            end
          end
        end
      end
      S_SYNC: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          odata_nxt = '{kind: KIND_LINE, line_byte: ~SYNC_CODE,
                        status: ST_OK, last: 1'b0};
          cnt_nxt   = len_c;
          state_nxt = S_LENB;
        end
      end
      S_LENB: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          odata_nxt = '{kind: KIND_LINE, line_byte: ~BYTE_W'(cnt_r),
                        status: ST_OK, last: 1'b0};
          state_nxt = (cnt_r == '0) ? S_TAIL : S_BYTE;
        end
      end
      S_BYTE: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          odata_nxt = '{kind: KIND_LINE, line_byte: ~rd_data,
                        status: ST_OK, last: 1'b0};
          rp_nxt    = pos_inc(rp_r);
          cnt_nxt   = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_nxt = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          pop       = 1'b1;
          ovld_nxt  = 1'b1;
          odata_nxt = '{kind: KIND_LINE, line_byte: (~CLEAR_CODE) & IDLE_CODE,
                        status: ST_OK, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_chan.valid = ovld_r;
  assign out_chan.data  = odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rp_r    <= '0;
      cwp_r   <= '0;
      wwp_r   <= '0;
      bcnt_r  <= '0;
      flen_r  <= '0;
      drop_r  <= 1'b0;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      cwp_r   <= cwp_nxt;
      wwp_r   <= wwp_nxt;
      bcnt_r  <= bcnt_nxt;
      flen_r  <= flen_nxt;
      drop_r  <= drop_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
  end
endmodule

>>> hw/rtl/packet_tx_ring_with_rollback.sv
// append: one registered status result per request; one append per cycle unless stalled
// drain: length + 3 line bytes, one per cycle unless the output stalls;
//   the length byte is fetched through the single ram read port before the sync byte
// empty drain: one result, like an append; a two-entry request queue buffers the input
// synchronous active-low reset clears pointers, counters, queue and output valid;
//   ring contents are not cleared (only committed bytes are ever read)
module packet_tx_ring_with_rollback #(
  parameter int BUF_DEPTH = ptrb_pkg::BUF_DEPTH_DEF,
  parameter int MAX_PKT   = ptrb_pkg::MAX_PKT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ptrb_chan_if.sink   in_chan,
  ptrb_chan_if.source out_chan
);
  import ptrb_pkg::*;

  op_req_t req;
  logic    pop;

  ptrb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .pop     (pop),
    .req     (req)
  );

  ptrb_back #(
    .BUF_DEPTH (BUF_DEPTH),
    .MAX_PKT   (MAX_PKT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .pop      (pop),
    .out_chan (out_chan)
  );

  a_pop_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> req.valid)
    else $error("request popped from empty queue");

  a_full_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> req.valid)
    else $error("input stalled with empty queue");

  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.data.kind == KIND_STATUS) |->
      (out_chan.data.last && out_chan.data.status != ST_EMPTY))
    else $error("bad append status result");

  a_line_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.data.kind == KIND_LINE && !out_chan.data.last) |->
      (out_chan.data.status == ST_OK))
    else $error("line byte with non-ok status");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid after reset");
endmodule

>>> verif/packet_tx_ring_with_rollback_test.sv
`timescale 1ns / 1ps

module packet_tx_ring_with_rollback_test;
  import ptrb_pkg::*;

  localparam int RING_DEPTH  = BUF_DEPTH_DEF;
  localparam int PKT_MAX     = MAX_PKT_DEF;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int RANDOM_REQS = 110;
  localparam int DRAIN_TAIL  = 2 * PKT_MAX;
  localparam int IN_W        = $bits(in_item_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ptrb_chan_if #(.payload_t(in_item_t))  in_if ();
  ptrb_chan_if #(.payload_t(out_item_t)) out_if ();

  packet_tx_ring_with_rollback #(
    .BUF_DEPTH(RING_DEPTH),
    .MAX_PKT(PKT_MAX)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_if),
    .out_chan(out_if)
  );

  always #5 clk = ~clk;

  // ring state as the block should hold it
  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
  int unsigned rd_pos = 0;
  int unsigned commit_pos = 0;
  int unsigned work_pos = 0;
  int unsigned pkt_count = 0;
  logic [BYTE_W-1:0] len_byte = '0;
  bit drop_mode = 1'b0;

  out_item_t tx_results_due[$];

  int errors = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int hold_off_left = 0;
  bit src_gaps = 1'b0;
  bit sink_stalls = 1'b0;

  function automatic out_item_t tx_result(logic kind, logic [BYTE_W-1:0] b, status_t s,
                                          logic last);
    out_item_t r;
    r.kind = kind;
    r.line_byte = b;
    r.status = s;
    r.last = last;
    return r;
  endfunction

  function automatic void compute_ring_response(in_item_t it);
    int unsigned nxt;
    int unsigned n;
    logic [BYTE_W-1:0] nb;
    if (op_code_t'(it.mode) == OP_APPEND) begin
      if (drop_mode) begin
        if (it.end_of_packet) drop_mode = 1'b0;
        tx_results_due.push_back(tx_result(KIND_STATUS, CLEAR_CODE, ST_OVF, 1'b1));
        return;
      end
      nxt = (work_pos + 1) % RING_DEPTH;
      if (nxt == rd_pos) begin
        work_pos = commit_pos;
        pkt_count = 0;
        drop_mode = !it.end_of_packet;
        tx_results_due.push_back(tx_result(KIND_STATUS, CLEAR_CODE, ST_OVF, 1'b1));
        return;
      end
      if (pkt_count == 0) len_byte = it.data_byte;
      ring_mem[work_pos] = it.data_byte;
      work_pos = nxt;
      if (pkt_count < COUNT_MAX) pkt_count++;
      if (!it.end_of_packet) begin
        tx_results_due.push_back(tx_result(KIND_STATUS, CLEAR_CODE, ST_OK, 1'b1));
      end else if (len_byte < MIN_LEN || len_byte > PKT_MAX || len_byte != pkt_count) begin
        work_pos = commit_pos;
        pkt_count = 0;
        tx_results_due.push_back(tx_result(KIND_STATUS, CLEAR_CODE, ST_MAL, 1'b1));
      end else begin
        commit_pos = work_pos;
        pkt_count = 0;
        tx_results_due.push_back(tx_result(KIND_STATUS, CLEAR_CODE, ST_OK, 1'b1));
      end
    end else begin
      if (commit_pos == rd_pos) begin
        tx_results_due.push_back(tx_result(KIND_LINE, CLEAR_CODE, ST_EMPTY, 1'b1));
        return;
      end
      n = ring_mem[rd_pos];
      if (n > PKT_MAX) n = PKT_MAX;
      nb = n[BYTE_W-1:0];
      tx_results_due.push_back(tx_result(KIND_LINE, ~SYNC_CODE, ST_OK, 1'b0));
      tx_results_due.push_back(tx_result(KIND_LINE, ~nb, ST_OK, 1'b0));
      for (int i = 0; i < n; i++) begin
        tx_results_due.push_back(tx_result(KIND_LINE, ~ring_mem[rd_pos], ST_OK, 1'b0));
        rd_pos = (rd_pos + 1) % RING_DEPTH;
      end
      tx_results_due.push_back(tx_result(KIND_LINE, ~CLEAR_CODE & IDLE_CODE, ST_OK, 1'b1));
    end
  endfunction

  // mostly short pauses, a few long ones
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 99) < 75) return $urandom_range(3, 12);
    return $urandom_range(13, PKT_MAX);
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.data <= it;
    forever begin
      @(posedge clk);
      if (in_if.ready) break;
    end
    compute_ring_response(it);
    items_sent++;
    gap = src_gaps ? pause_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_append(input logic [BYTE_W-1:0] b, input logic eop);
    in_item_t it;
    it.mode = OP_APPEND;
    it.data_byte = b;
    it.end_of_packet = eop;
    send_item(it);
  endtask

  task automatic send_drain();
    in_item_t it;
    it.mode = OP_DRAIN;
    it.data_byte = BYTE_W'($urandom_range(0, 255));
    it.end_of_packet = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // first byte carries the length field, last byte carries end of packet
  task automatic send_packet(input logic [BYTE_W-1:0] len_field, input int nbytes,
                             input int drain_pct);
    for (int i = 0; i < nbytes; i++) begin
      if (drain_pct > 0 && $urandom_range(0, 99) < drain_pct) send_drain();
      send_append(i == 0 ? len_field : BYTE_W'($urandom_range(0, 255)), i == nbytes - 1);
    end
  endtask

  task automatic test_empty_drain();
    send_drain();
  endtask

  task automatic test_extreme_packets();
    send_append(MIN_LEN, 1'b0);
    send_append(8'h00, 1'b0);
    send_append(8'hff, 1'b1);
    send_packet(BYTE_W'(PKT_MAX), PKT_MAX, 0);
    send_drain();
    send_drain();
    send_drain();
  endtask

  task automatic test_malformed();
    send_append(8'd2, 1'b0);
    send_append(8'haa, 1'b1);
    send_packet(BYTE_W'(PKT_MAX + 1), PKT_MAX + 1, 0);
    send_packet(8'd5, 4, 0);
    send_packet(8'd4, 5, 0);
    send_append(8'h00, 1'b1);
    send_append(8'hff, 1'b1);
    send_drain();
  endtask

  task automatic test_open_packet();
    send_packet(8'd4, 4, 0);
    send_append(8'd6, 1'b0);
    send_append(8'h5a, 1'b0);
    send_drain();
    send_drain();
    send_packet(8'd0, 4, 0);
    send_drain();
  endtask

  // two full packets leave five free entries in the ring
  task automatic test_overflow();
    send_packet(BYTE_W'(PKT_MAX), PKT_MAX, 0);
    send_packet(BYTE_W'(PKT_MAX), PKT_MAX, 0);
    send_packet(8'd10, 10, 0);
    send_packet(8'd6, 6, 0);
    send_drain();
    send_drain();
    send_drain();
  endtask

  task automatic test_backpressure();
    sink_stalls = 1'b0;
    hold_off_left = 400;
    send_packet(8'd8, 8, 0);
    send_drain();
    send_packet(8'd5, 5, 0);
    send_drain();
    send_drain();
    send_packet(8'd3, 3, 0);
  endtask

  task automatic test_random_traffic();
    int start;
    int sel;
    int len;
    int kind_sel;
    in_item_t it;
    start = items_sent;
    while (items_sent - start < RANDOM_REQS) begin
      if ($urandom_range(0, 9) == 0) begin
        src_gaps = 1'($urandom_range(0, 1));
        sink_stalls = 1'($urandom_range(0, 1));
      end
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        len = pick_len();
        send_packet(BYTE_W'(len), len, 3);
      end else if (sel < 85) begin
        send_drain();
      end else if (sel < 93) begin
        kind_sel = $urandom_range(0, 2);
        len = pick_len();
        if (kind_sel == 0) begin
          send_packet(BYTE_W'(len), $urandom_range(0, 1) ? len - 1 : len + 1, 0);
        end else if (kind_sel == 1) begin
          send_packet(BYTE_W'($urandom_range(0, 2)), $urandom_range(1, 6), 0);
        end else begin
          send_packet(BYTE_W'($urandom_range(PKT_MAX + 1, 255)), $urandom_range(1, 12), 0);
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          it = in_item_t'(IN_W'($urandom));
          send_item(it);
        end
      end
    end
  endtask

  // receiver pacing, including the long hold-off
  initial begin : sink_pacing
    int stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_if.ready <= 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 7) == 0) stall_left = pause_len();
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    out_item_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (tx_results_due.size() == 0) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: unexpected result expected none actual kind=%0d byte=%02h status=%0d last=%0d",
                   $time, got.kind, got.line_byte, got.status, got.last);
        end
      end else begin
        want = tx_results_due.pop_front();
        if (got.kind !== want.kind || got.line_byte !== want.line_byte ||
            got.status !== want.status || got.last !== want.last) begin
          errors++;
          if (errors <= 40) begin
            $display("%0t: mismatch expected kind=%0d byte=%02h status=%0d last=%0d actual kind=%0d byte=%02h status=%0d last=%0d",
                     $time, want.kind, want.line_byte, want.status, want.last,
                     got.kind, got.line_byte, got.status, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_empty_drain();
    test_extreme_packets();
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    test_malformed();
    test_open_packet();
    src_gaps = 1'b0;
    test_overflow();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (tx_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ptrb_pkg.sv
hw/rtl/ptrb_chan_if.sv
hw/rtl/ptrb_ram.sv
hw/rtl/ptrb_front.sv
hw/rtl/ptrb_back.sv
hw/rtl/packet_tx_ring_with_rollback.sv
verif/packet_tx_ring_with_rollback_test.sv
